// File: rtl/block_nesting_checker_core_defines.svh
// Assertion macros shared by the block nesting checker.
`ifndef BLOCK_NESTING_CHECKER_CORE_DEFINES_SVH
`define BLOCK_NESTING_CHECKER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BNC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BNC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/bnc_pkg.sv
package bnc_pkg;

   // Statement kind codes as classified upstream.
   localparam logic [4:0] KIND_OTHER     = 5'd0;
   localparam logic [4:0] KIND_IF_HDR    = 5'd1;
   localparam logic [4:0] KIND_IF_INLINE = 5'd2;
   localparam logic [4:0] KIND_THEN      = 5'd3;
   localparam logic [4:0] KIND_ELSE      = 5'd4;
   localparam logic [4:0] KIND_ENDIF     = 5'd5;
   localparam logic [4:0] KIND_CASE_HDR  = 5'd6;
   localparam logic [4:0] KIND_CASE      = 5'd7;
   localparam logic [4:0] KIND_OTHERWISE = 5'd8;
   localparam logic [4:0] KIND_ENDCASE   = 5'd9;
   localparam logic [4:0] KIND_FOR_HDR   = 5'd10;
   localparam logic [4:0] KIND_FOR_STEP  = 5'd11;
   localparam logic [4:0] KIND_NEXT      = 5'd12;
   localparam logic [4:0] KIND_WHILE     = 5'd13;
   localparam logic [4:0] KIND_ENDWHILE  = 5'd14;
   localparam logic [4:0] KIND_REPEAT    = 5'd15;
   localparam logic [4:0] KIND_UNTIL     = 5'd16;
   localparam logic [4:0] KIND_TRY       = 5'd17;
   localparam logic [4:0] KIND_EXCEPT    = 5'd18;
   localparam logic [4:0] KIND_ENDTRY    = 5'd19;
   localparam logic [4:0] KIND_PROC      = 5'd20;
   localparam logic [4:0] KIND_ENDPROC   = 5'd21;
   localparam logic [4:0] KIND_FUNC      = 5'd22;
   localparam logic [4:0] KIND_ENDFUNC   = 5'd23;
   localparam logic [4:0] KIND_CONTINUE  = 5'd24;
   localparam logic [4:0] KIND_BREAK     = 5'd25;
   localparam logic [4:0] KIND_RETURN    = 5'd26;
   localparam logic [4:0] KIND_END       = 5'd27;

   typedef enum logic [2:0] {
      BLK_IF, BLK_CASE, BLK_FOR, BLK_WHILE, BLK_REPEAT, BLK_TRY, BLK_PROC, BLK_FUNC
   } block_type;

   typedef enum logic [3:0] {
      ERR_NONE, ERR_TOO_DEEP, ERR_NO_HEADER, ERR_DUP_TAG, ERR_NO_THEN,
      ERR_OTHERWISE_FIRST, ERR_SUB_NESTED, ERR_NO_LOOP, ERR_RETURN_OUTSIDE,
      ERR_UNCLOSED
   } error_type;

   typedef enum logic [2:0] {
      LINK_NONE, LINK_OWN, LINK_TOP, LINK_LOOP, LINK_BASE
   } link_sel_type;

   // Fields of the top stack entry that the decision logic looks at.
   typedef struct packed {
      block_type  blk;
      logic [1:0] tag;
      logic       ow;
      logic       loop_valid;
   } top_info_type;

   // Actions decided for one transaction.
   typedef struct packed {
      logic         push;
      logic         pop;
      logic         upd_top;
      block_type    push_blk;
      logic [1:0]   tag_next;
      logic         ow_next;
      link_sel_type link_sel;
      error_type    err;
   } ctrl_type;

   function automatic logic is_loop(block_type blk);
      return (blk == BLK_FOR) || (blk == BLK_WHILE) || (blk == BLK_REPEAT);
   endfunction

   function automatic logic is_sub(block_type blk);
      return (blk == BLK_PROC) || (blk == BLK_FUNC);
   endfunction

endpackage

// File: rtl/block_nesting_checker_core.sv
// Block nesting checker: takes one classified statement per transaction and
// returns one result transaction: the header line the statement links to,
// an error code, or neither; the first error latches and every later statement
// reports it again without touching the stack. The accept edge also reads the
// top stack entry from a synchronous single-port-read memory, and the commit
// edge that follows it commits the decision, writes the memory and loads the
// result register. A new statement is accepted while an earlier result still
// waits at the output; commit of the new one waits only if that result has
// still not been taken. No clearing pass runs after reset: stack data is
// relied on only at levels already written.
module block_nesting_checker_core #(
   parameter int MAX_DEPTH = 128,
   parameter int LINE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [4:0]           req_stmt_kind,
   input  logic [LINE_BITS-1:0] req_line_number,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_link_valid,
   output logic [LINE_BITS-1:0] rsp_link_line,
   output logic [3:0]           rsp_error_code,
   output logic                 rsp_error_latched
);

`include "block_nesting_checker_core_defines.svh"

   localparam int ADDR_BITS  = $clog2(MAX_DEPTH);
   localparam int DEPTH_BITS = $clog2(MAX_DEPTH + 1);

   // One stack level. The nearest enclosing loop header is worked out when
   // the level is pushed, so CONTINUE and BREAK only need the top entry.
   typedef struct packed {
      bnc_pkg::block_type   blk;
      logic [1:0]           tag;
      logic                 ow;
      logic                 loop_valid;
      logic [LINE_BITS-1:0] line;
      logic [LINE_BITS-1:0] loop_line;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef enum logic {ST_IDLE, ST_EXEC} state_type;

   state_type            state_ff, state_in;
   logic [4:0]           kind_ff;
   logic [LINE_BITS-1:0] line_ff;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   bnc_pkg::error_type   sticky_ff, sticky_in;
   logic                 base_is_sub_ff;
   logic [LINE_BITS-1:0] base_line_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_link_valid_ff, rsp_link_valid_in;
   logic [LINE_BITS-1:0] rsp_link_line_ff, rsp_link_line_in;
   logic [3:0]           rsp_error_code_ff, rsp_error_code_in;
   logic                 rsp_error_latched_ff, rsp_error_latched_in;

   logic                  accept;
   logic                  commit;
   logic                  depth_zero;
   logic                  depth_full;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic                  wr_en;
   logic [ENTRY_BITS-1:0] rd_data;
   entry_type             top_entry;
   entry_type             wr_entry;
   bnc_pkg::top_info_type top_info;
   bnc_pkg::ctrl_type     ctrl;
   logic                  push_loop;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   // The result register must be free (or emptying now) before commit.
   assign commit    = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   assign depth_zero = (depth_ff == '0);
   assign depth_full = (depth_ff == DEPTH_BITS'(MAX_DEPTH));

   // The depth only changes at commit, so the read issued at the accept edge
   // already sees the entry written by the previous statement.
   assign rd_addr = depth_zero ? '0 : ADDR_BITS'(depth_ff - DEPTH_BITS'(1));
   assign wr_addr = ctrl.push ? depth_ff[ADDR_BITS-1:0] : rd_addr;
   assign wr_en   = commit && (ctrl.push || ctrl.upd_top);

   assign top_entry = entry_type'(rd_data);

   assign top_info.blk        = top_entry.blk;
   assign top_info.tag        = top_entry.tag;
   assign top_info.ow         = top_entry.ow;
   assign top_info.loop_valid = top_entry.loop_valid;

   bnc_stack_mem #(
      .DEPTH (MAX_DEPTH),
      .WIDTH (ENTRY_BITS)
   ) u_stack_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bnc_decide u_decide (
      .kind        (kind_ff),
      .sticky      (sticky_ff),
      .depth_zero  (depth_zero),
      .depth_full  (depth_full),
      .top         (top_info),
      .base_is_sub (base_is_sub_ff),
      .ctrl        (ctrl)
   );

   // A pushed level either is a loop itself or inherits the loop link of
   // the level below it. A tag update rewrites the top entry with its new
   // tag count and OTHERWISE flag.
   always_comb begin
      push_loop = bnc_pkg::is_loop(ctrl.push_blk);
      if (ctrl.push) begin
         wr_entry.blk        = ctrl.push_blk;
         wr_entry.tag        = ctrl.tag_next;
         wr_entry.ow         = 1'b0;
         wr_entry.line       = line_ff;
         wr_entry.loop_valid = push_loop || (!depth_zero && top_entry.loop_valid);
         wr_entry.loop_line  = push_loop ? line_ff : top_entry.loop_line;
      end else begin
         wr_entry     = top_entry;
         wr_entry.tag = ctrl.tag_next;
         wr_entry.ow  = ctrl.ow_next;
      end
   end

   // Next-state logic for the sequencer, the stack depth, the latched error
   // and the result register.
   always_comb begin
      state_in             = state_ff;
      depth_in             = depth_ff;
      sticky_in            = sticky_ff;
      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      rsp_link_valid_in    = rsp_link_valid_ff;
      rsp_link_line_in     = rsp_link_line_ff;
      rsp_error_code_in    = rsp_error_code_ff;
      rsp_error_latched_in = rsp_error_latched_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (ctrl.err != bnc_pkg::ERR_NONE) begin
                  sticky_in            = ctrl.err;
                  rsp_link_valid_in    = 1'b0;
                  rsp_link_line_in     = '0;
                  rsp_error_code_in    = 4'(ctrl.err);
                  rsp_error_latched_in = 1'b1;
               end else begin
                  if (ctrl.push) begin
                     depth_in = depth_ff + DEPTH_BITS'(1);
                  end else if (ctrl.pop) begin
                     depth_in = depth_ff - DEPTH_BITS'(1);
                  end
                  rsp_link_valid_in    = (ctrl.link_sel != bnc_pkg::LINK_NONE);
                  rsp_error_code_in    = 4'(bnc_pkg::ERR_NONE);
                  rsp_error_latched_in = 1'b0;
                  case (ctrl.link_sel)
                     bnc_pkg::LINK_OWN:  rsp_link_line_in = line_ff;
                     bnc_pkg::LINK_TOP:  rsp_link_line_in = top_entry.line;
                     bnc_pkg::LINK_LOOP: rsp_link_line_in = top_entry.loop_line;
                     bnc_pkg::LINK_BASE: rsp_link_line_in = base_line_ff;
                     default:            rsp_link_line_in = '0;
                  endcase
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= ST_IDLE;
         depth_ff             <= '0;
         sticky_ff            <= bnc_pkg::ERR_NONE;
         rsp_valid_ff         <= 1'b0;
         rsp_link_valid_ff    <= 1'b0;
         rsp_link_line_ff     <= '0;
         rsp_error_code_ff    <= '0;
         rsp_error_latched_ff <= 1'b0;
      end else begin
         state_ff             <= state_in;
         depth_ff             <= depth_in;
         sticky_ff            <= sticky_in;
         rsp_valid_ff         <= rsp_valid_in;
         rsp_link_valid_ff    <= rsp_link_valid_in;
         rsp_link_line_ff     <= rsp_link_line_in;
         rsp_error_code_ff    <= rsp_error_code_in;
         rsp_error_latched_ff <= rsp_error_latched_in;
      end
   end

   // Statement capture and the bottom-level record used by RETURN. The
   // bottom record is read only while at least one level is open.
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_stmt_kind;
         line_ff <= req_line_number;
      end
      if (commit && ctrl.push && depth_zero && ctrl.err == bnc_pkg::ERR_NONE) begin
         base_is_sub_ff <= bnc_pkg::is_sub(ctrl.push_blk);
         base_line_ff   <= line_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_link_valid    = rsp_link_valid_ff;
   assign rsp_link_line     = rsp_link_line_ff;
   assign rsp_error_code    = rsp_error_code_ff;
   assign rsp_error_latched = rsp_error_latched_ff;

   `BNC_ASSERT_SAME(a_depth_bound, clock, reset, 1'b1, depth_ff <= DEPTH_BITS'(MAX_DEPTH), "stack depth above limit")
   `BNC_ASSERT_NEXT(a_sticky_holds, clock, reset, sticky_ff != bnc_pkg::ERR_NONE, $stable(sticky_ff), "latched error changed")
   `BNC_ASSERT_NEXT(a_error_keeps_depth, clock, reset, commit && ctrl.err != bnc_pkg::ERR_NONE, $stable(depth_ff), "stack moved on an error")
   `BNC_ASSERT_SAME(a_error_no_link, clock, reset, rsp_valid_ff && rsp_error_latched_ff, !rsp_link_valid_ff && rsp_error_code_ff != 4'(bnc_pkg::ERR_NONE), "error result carries a link")

endmodule

// File: rtl/bnc_stack_mem.sv
module bnc_stack_mem #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 39
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: rtl/bnc_decide.sv
module bnc_decide (
   input  logic [4:0]            kind,
   input  bnc_pkg::error_type    sticky,
   input  logic                  depth_zero,
   input  logic                  depth_full,
   input  bnc_pkg::top_info_type top,
   input  logic                  base_is_sub,
   output bnc_pkg::ctrl_type     ctrl
);

   always_comb begin
      bnc_pkg::block_type want;
      logic [1:0]         init_tag;
      logic [1:0]         bumped;
      logic               top_match;

      want     = bnc_pkg::BLK_IF;
      init_tag = 2'd1;
      case (kind)
         bnc_pkg::KIND_IF_INLINE: init_tag = 2'd2;
         default: init_tag = 2'd1;
      endcase

      // Block kind a header opens or a tag or ender expects on top.
      case (kind) inside
         bnc_pkg::KIND_IF_HDR, bnc_pkg::KIND_IF_INLINE, bnc_pkg::KIND_THEN,
         bnc_pkg::KIND_ELSE, bnc_pkg::KIND_ENDIF: want = bnc_pkg::BLK_IF;
         bnc_pkg::KIND_CASE_HDR, bnc_pkg::KIND_CASE, bnc_pkg::KIND_OTHERWISE,
         bnc_pkg::KIND_ENDCASE: want = bnc_pkg::BLK_CASE;
         bnc_pkg::KIND_FOR_HDR, bnc_pkg::KIND_FOR_STEP,
         bnc_pkg::KIND_NEXT: want = bnc_pkg::BLK_FOR;
         bnc_pkg::KIND_WHILE, bnc_pkg::KIND_ENDWHILE: want = bnc_pkg::BLK_WHILE;
         bnc_pkg::KIND_REPEAT, bnc_pkg::KIND_UNTIL: want = bnc_pkg::BLK_REPEAT;
         bnc_pkg::KIND_TRY, bnc_pkg::KIND_EXCEPT,
         bnc_pkg::KIND_ENDTRY: want = bnc_pkg::BLK_TRY;
         bnc_pkg::KIND_PROC, bnc_pkg::KIND_ENDPROC: want = bnc_pkg::BLK_PROC;
         bnc_pkg::KIND_FUNC, bnc_pkg::KIND_ENDFUNC: want = bnc_pkg::BLK_FUNC;
         default: want = bnc_pkg::BLK_IF;
      endcase

      top_match = !depth_zero && (top.blk == want);
      bumped    = (top.tag == 2'd3) ? 2'd3 : top.tag + 2'd1;

      ctrl.push     = 1'b0;
      ctrl.pop      = 1'b0;
      ctrl.upd_top  = 1'b0;
      ctrl.push_blk = want;
      ctrl.tag_next = bumped;
      ctrl.ow_next  = top.ow;
      ctrl.link_sel = bnc_pkg::LINK_NONE;
      ctrl.err      = bnc_pkg::ERR_NONE;

      if (sticky != bnc_pkg::ERR_NONE) begin
         ctrl.err = sticky;
      end else begin
         case (kind) inside
            bnc_pkg::KIND_IF_HDR, bnc_pkg::KIND_IF_INLINE, bnc_pkg::KIND_CASE_HDR,
            bnc_pkg::KIND_FOR_HDR, bnc_pkg::KIND_FOR_STEP, bnc_pkg::KIND_WHILE,
            bnc_pkg::KIND_REPEAT, bnc_pkg::KIND_TRY: begin
               if (depth_full) begin
                  ctrl.err = bnc_pkg::ERR_TOO_DEEP;
               end else begin
                  ctrl.push     = 1'b1;
                  ctrl.tag_next = init_tag;
                  ctrl.link_sel = bnc_pkg::LINK_OWN;
               end
            end
            bnc_pkg::KIND_THEN, bnc_pkg::KIND_EXCEPT, bnc_pkg::KIND_ELSE: begin
               if (!top_match) begin
                  ctrl.err = bnc_pkg::ERR_NO_HEADER;
               end else if (top.tag != ((kind == bnc_pkg::KIND_ELSE) ? 2'd2 : 2'd1)) begin
                  ctrl.err = bnc_pkg::ERR_DUP_TAG;
               end else begin
                  ctrl.upd_top  = 1'b1;
                  ctrl.link_sel = bnc_pkg::LINK_TOP;
               end
            end
            bnc_pkg::KIND_ENDIF: begin
               if (!top_match) begin
                  ctrl.err = bnc_pkg::ERR_NO_HEADER;
               end else if (top.tag == 2'd1) begin
                  ctrl.err = bnc_pkg::ERR_NO_THEN;
               end else begin
                  ctrl.pop      = 1'b1;
                  ctrl.link_sel = bnc_pkg::LINK_TOP;
               end
            end
            bnc_pkg::KIND_CASE: begin
               if (!top_match) begin
                  ctrl.err = bnc_pkg::ERR_NO_HEADER;
               end else begin
                  ctrl.upd_top  = 1'b1;
                  ctrl.link_sel = bnc_pkg::LINK_TOP;
               end
            end
            bnc_pkg::KIND_OTHERWISE: begin
               if (!top_match) begin
                  ctrl.err = bnc_pkg::ERR_NO_HEADER;
               end else if (top.tag == 2'd1) begin
                  ctrl.err = bnc_pkg::ERR_OTHERWISE_FIRST;
               end else if (top.ow) begin
                  ctrl.err = bnc_pkg::ERR_DUP_TAG;
               end else begin
                  ctrl.upd_top  = 1'b1;
                  ctrl.ow_next  = 1'b1;
                  ctrl.link_sel = bnc_pkg::LINK_TOP;
               end
            end
            bnc_pkg::KIND_ENDCASE, bnc_pkg::KIND_NEXT, bnc_pkg::KIND_ENDWHILE,
            bnc_pkg::KIND_UNTIL, bnc_pkg::KIND_ENDTRY, bnc_pkg::KIND_ENDPROC,
            bnc_pkg::KIND_ENDFUNC: begin
               if (!top_match) begin
                  ctrl.err = bnc_pkg::ERR_NO_HEADER;
               end else begin
                  ctrl.pop      = 1'b1;
                  ctrl.link_sel = bnc_pkg::LINK_TOP;
               end
            end
            bnc_pkg::KIND_PROC, bnc_pkg::KIND_FUNC: begin
               if (!depth_zero) begin
                  ctrl.err = bnc_pkg::ERR_SUB_NESTED;
               end else begin
                  ctrl.push     = 1'b1;
                  ctrl.tag_next = init_tag;
                  ctrl.link_sel = bnc_pkg::LINK_OWN;
               end
            end
            bnc_pkg::KIND_CONTINUE, bnc_pkg::KIND_BREAK: begin
               if (depth_zero || !top.loop_valid) begin
                  ctrl.err = bnc_pkg::ERR_NO_LOOP;
               end else begin
                  ctrl.link_sel = bnc_pkg::LINK_LOOP;
               end
            end
            bnc_pkg::KIND_RETURN: begin
               if (depth_zero || !base_is_sub) begin
                  ctrl.err = bnc_pkg::ERR_RETURN_OUTSIDE;
               end else begin
                  ctrl.link_sel = bnc_pkg::LINK_BASE;
               end
            end
            bnc_pkg::KIND_END: begin
               if (!depth_zero) begin
                  ctrl.err = bnc_pkg::ERR_UNCLOSED;
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule
